[sv/edm_pkg.sv]
// Shared types and constants for the Euclidean divide/modulo pipeline.
// Used by edm_div_step and euclidean_divide_modulo; depends on nothing.
package edm_pkg;

    // Operand and result width
    localparam int WIDTH = 32;

    // Constant one at operand width
    localparam logic [WIDTH-1:0] ONE_W = {{(WIDTH-1){1'b0}}, 1'b1};

    // Sign and special-case flags that ride along with each item
    typedef struct packed {
        logic a_neg;     // signed mode and dividend negative
        logic b_neg;     // signed mode and divisor negative
        logic div_zero;  // divisor is zero
    } ctl_t;

    // One item as it moves through the divide array
    typedef struct packed {
        logic [WIDTH-1:0] rem;  // partial remainder
        logic [WIDTH-1:0] quo;  // dividend bits shifting out, quotient bits shifting in
        logic [WIDTH-1:0] dvs;  // divisor magnitude
        ctl_t             ctl;
    } step_t;

endpackage

[sv/edm_div_step.sv]
// One restoring-division stage: retires one quotient bit per item.
// Depends on edm_pkg for the stage payload type.
module edm_div_step (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          adv,
    input  logic          vld_in,
    input  edm_pkg::step_t data_in,
    output logic          vld_out,
    output edm_pkg::step_t data_out
);

    logic [edm_pkg::WIDTH:0]   trial;
    logic [edm_pkg::WIDTH:0]   diff;
    logic                      take;
    edm_pkg::step_t            data_next;
    edm_pkg::step_t            data_reg;
    logic                      vld_reg;

    // Shift in the next dividend bit and try a subtract of the divisor
    always_comb
    begin
        trial = {data_in.rem, data_in.quo[edm_pkg::WIDTH-1]};
        diff  = trial - {1'b0, data_in.dvs};
        take  = !diff[edm_pkg::WIDTH];
        data_next     = data_in;
        data_next.rem = take ? diff[edm_pkg::WIDTH-1:0] : trial[edm_pkg::WIDTH-1:0];
        data_next.quo = {data_in.quo[edm_pkg::WIDTH-2:0], take};
    end

    // Advance valid with the pipeline, hold under stall
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            vld_reg <= vld_in;
        end
    end

    // Advance payload
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            data_reg <= data_next;
        end
    end

    assign vld_out  = vld_reg;
    assign data_out = data_reg;

    // Restoring invariant: partial remainder stays below a nonzero divisor
    a_rem_below_dvs: assert property (@(posedge clk) disable iff (!rst_n)
        (vld_reg && !data_reg.ctl.div_zero) |-> (data_reg.rem < data_reg.dvs))
        else $error("partial remainder not below divisor");

    // A held stage keeps its payload
    a_hold_payload: assert property (@(posedge clk) disable iff (!rst_n)
        (!adv && vld_reg) |=> $stable(data_reg))
        else $error("stage payload changed while held");

    // Zero-divisor flag only arises with a zero divisor
    a_zero_flag: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg |-> (data_reg.ctl.div_zero == (data_reg.dvs == '0)))
        else $error("zero-divisor flag disagrees with divisor");

endmodule

[sv/euclidean_divide_modulo.sv]
// Top level of the Euclidean divide/modulo pipeline.
// Depends on edm_pkg and edm_div_step.
//
// Euclidean divide/modulo, WIDTH bits. One transfer is accepted per cycle
// while req_stall is low. Each item passes through the operand register,
// then one restoring-division stage per quotient bit, then the
// sign-correction output register; a result-side stall holds it in place.
// Throughput is one item per cycle while the result side does not stall,
// set by the stage-per-bit divide array. The remainder always lies in
// 0 to |divisor|-1; a zero divisor gives quotient 0 and remainder 0, and in
// signed mode the most negative value over -1 wraps to the most negative
// value. A stall on the result side while a result is held freezes the
// whole pipeline and drives req_stall; no item is dropped or repeated.
module euclidean_divide_modulo (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      req_valid,
    output logic                      req_stall,
    input  logic [edm_pkg::WIDTH-1:0] dividend,
    input  logic [edm_pkg::WIDTH-1:0] divisor,
    input  logic                      is_signed,
    output logic                      rsp_valid,
    input  logic                      rsp_stall,
    output logic [edm_pkg::WIDTH-1:0] quotient,
    output logic [edm_pkg::WIDTH-1:0] remainder
);

    localparam int W = edm_pkg::WIDTH;

    logic                 adv;
    logic                 a_neg;
    logic                 b_neg;
    edm_pkg::step_t       prep_next;
    edm_pkg::step_t       pipe [0:W];
    logic [W:0]           pipe_vld;
    edm_pkg::step_t       prep_reg;
    logic                 prep_vld_reg;
    edm_pkg::step_t       last;
    logic [W-1:0]         q0;
    logic [W-1:0]         r0;
    logic [W-1:0]         quotient_next;
    logic [W-1:0]         remainder_next;
    logic [W-1:0]         quotient_reg;
    logic [W-1:0]         remainder_reg;
    logic                 rsp_valid_reg;

    // Whole pipeline moves unless a finished result is held
    assign adv       = !(rsp_valid_reg && rsp_stall);
    assign req_stall = !adv;

    // Take operand magnitudes and sign flags
    always_comb
    begin
        a_neg = is_signed && dividend[W-1];
        b_neg = is_signed && divisor[W-1];
        prep_next.rem          = '0;
        prep_next.quo          = a_neg ? (~dividend + edm_pkg::ONE_W) : dividend;
        prep_next.dvs          = b_neg ? (~divisor + edm_pkg::ONE_W) : divisor;
        prep_next.ctl.a_neg    = a_neg;
        prep_next.ctl.b_neg    = b_neg;
        prep_next.ctl.div_zero = (divisor == '0);
    end

    // Operand stage valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prep_vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            prep_vld_reg <= req_valid;
        end
    end

    // Operand stage payload
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            prep_reg <= prep_next;
        end
    end

    assign pipe[0]     = prep_reg;
    assign pipe_vld[0] = prep_vld_reg;

    // Divide array: one quotient bit per stage
    for (genvar k = 0; k < W; k++)
    begin : g_step
        edm_div_step u_step (
            .clk      (clk),
            .rst_n    (rst_n),
            .adv      (adv),
            .vld_in   (pipe_vld[k]),
            .data_in  (pipe[k]),
            .vld_out  (pipe_vld[k+1]),
            .data_out (pipe[k+1])
        );
    end

    // Correct truncated quotient and remainder by the signs
    always_comb
    begin
        last = pipe[W];
        q0   = last.quo;
        r0   = last.rem;
        if (last.ctl.div_zero)
        begin
            quotient_next  = '0;
            remainder_next = '0;
        end
        else if (!last.ctl.a_neg)
        begin
            quotient_next  = last.ctl.b_neg ? (~q0 + edm_pkg::ONE_W) : q0;
            remainder_next = r0;
        end
        else if (r0 == '0)
        begin
            quotient_next  = last.ctl.b_neg ? q0 : (~q0 + edm_pkg::ONE_W);
            remainder_next = '0;
        end
        else
        begin
            // Step one away from zero: -(q0 + 1) is ~q0
            quotient_next  = last.ctl.b_neg ? (q0 + edm_pkg::ONE_W) : ~q0;
            remainder_next = last.dvs - r0;
        end
    end

    // Output register valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            rsp_valid_reg <= pipe_vld[W];
        end
    end

    // Output register payload
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            quotient_reg  <= quotient_next;
            remainder_reg <= remainder_next;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign quotient  = quotient_reg;
    assign remainder = remainder_reg;

    // Input side stalls only behind a held result
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        req_stall |-> rsp_valid)
        else $error("input stalled with no result waiting");

    // A stalled pipeline keeps every valid bit in place
    a_vld_frozen: assert property (@(posedge clk) disable iff (!rst_n)
        !adv |=> $stable(pipe_vld))
        else $error("pipeline valid bits moved during stall");

    // Final remainder from the array is below the divisor magnitude
    a_final_rem: assert property (@(posedge clk) disable iff (!rst_n)
        (pipe_vld[W] && !last.ctl.div_zero) |-> (r0 < last.dvs))
        else $error("final truncated remainder out of range");

    // Corrected remainder also stays below the divisor magnitude
    a_corr_rem: assert property (@(posedge clk) disable iff (!rst_n)
        (pipe_vld[W] && !last.ctl.div_zero) |-> (remainder_next < last.dvs))
        else $error("corrected remainder out of range");

endmodule
